@@ rtl/core/ppsh_pkg.sv @@
package ppsh_pkg;

  // Bit positions in the status and control words.
  localparam int unsigned ACK_BIT              = 12;
  localparam int unsigned NEW_SETPOINT_BIT     = 4;
  localparam int unsigned CHANGE_IMMEDIATE_BIT = 5;

  // Register defaults and counter width.
  localparam logic [9:0]  ACK_TIMEOUT_RESET = 10'd200;
  localparam int unsigned WAIT_COUNT_W      = 11;
  localparam logic [WAIT_COUNT_W-1:0] WAIT_COUNT_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_CHANGE_IMMEDIATELY = 1'b0,
    CFG_ACK_TIMEOUT        = 1'b1
  } cfg_index_t;

  // One input beat.
  typedef struct packed {
    logic [15:0]        status_word;
    logic               drive_operational;
    logic [15:0]        base_control;
    logic signed [31:0] actual_position;
    logic               target_valid;
    logic signed [31:0] target_position;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [15:0]        control_word;
    logic signed [31:0] commanded_position;
  } rsp_t;

  // Settings shared by the register file and the handshake logic.
  typedef struct packed {
    logic       change_immediately;
    logic [9:0] ack_timeout;
  } cfg_t;

endpackage

@@ rtl/core/profile_position_setpoint_handshake_unit.sv @@
// Channel   Signals                                  Direction  Beat
// -------   ---------------------------------------  ---------  ----------------------
// req       req_valid, req_stall, req                in         one bus-cycle sample
// rsp       rsp_valid, rsp_stall, rsp                out        control word, position
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in        one register write
//
// One beat per clock is sustained while the result is not stalled. An accepted
// request loads the input register; the beat then passes through the handshake logic
// into the result register when that register is free. Reset (rst, synchronous)
// clears the handshake state and loads change_immediately = 0, ack_timeout = 200.
// A stalled result holds the result register, and the input register then absorbs
// one more request beat.
module profile_position_setpoint_handshake_unit
  import ppsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t cfg;
  logic held_valid;
  req_t held;
  logic take;

  // Configuration registers.
  ppsh_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  ppsh_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .held_valid (held_valid),
    .held       (held),
    .take       (take)
  );

  // Handshake logic and result register.
  ppsh_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held       (held),
    .take       (take),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

@@ rtl/core/ppsh_cfg_regs.sv @@
module ppsh_cfg_regs
  import ppsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [9:0] cfg_data,
  output cfg_t       cfg
);

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  // Register writes by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_immediately <= 1'b0;
      cfg.ack_timeout        <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANGE_IMMEDIATELY: cfg.change_immediately <= cfg_data[0];
        CFG_ACK_TIMEOUT:        cfg.ack_timeout        <= cfg_data;
        default:                cfg.ack_timeout        <= cfg.ack_timeout;
      endcase
    end
  end

endmodule

@@ rtl/core/ppsh_in_reg.sv @@
module ppsh_in_reg
  import ppsh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic held_valid,
  output req_t held,
  input  logic take
);

  // The register stalls only when it holds a beat that cannot move on.
  assign req_stall = held_valid && !take;

  // Valid flag of the held beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  // Payload is loaded on every accepted beat.
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      held <= req;
    end
  end

endmodule

@@ rtl/core/ppsh_step.sv @@
module ppsh_step
  import ppsh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic held_valid,
  input  req_t held,
  output logic take,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic                    setpoint_bit_high, setpoint_bit_high_next;
  logic                    waiting_for_ack, waiting_for_ack_next;
  logic                    waiting_for_ack_clear, waiting_for_ack_clear_next;
  logic [WAIT_COUNT_W-1:0] wait_count, wait_count_next;
  logic                    accepted_valid, accepted_valid_next;
  logic signed [31:0]      accepted_target, accepted_target_next;
  rsp_t                    rsp_next;
  logic                    ack;
  logic [WAIT_COUNT_W-1:0] count_inc;
  logic                    expired;

  // A held beat moves on when the result register is empty or being drained.
  assign take = held_valid && (!rsp_valid || !rsp_stall);

  // Saturating count of wait cycles and timeout check.
  assign ack       = held.status_word[ACK_BIT];
  assign count_inc = (wait_count == WAIT_COUNT_MAX) ? wait_count : wait_count + 1'b1;
  assign expired   = count_inc > {1'b0, cfg.ack_timeout};

  // Handshake update and result for the held beat.
  always_comb begin
    setpoint_bit_high_next     = setpoint_bit_high;
    waiting_for_ack_next       = waiting_for_ack;
    waiting_for_ack_clear_next = waiting_for_ack_clear;
    wait_count_next            = wait_count;
    accepted_valid_next        = accepted_valid;
    accepted_target_next       = accepted_target;
    rsp_next.control_word       = held.base_control;
    rsp_next.commanded_position = held.actual_position;

    if (!held.drive_operational) begin
      setpoint_bit_high_next     = 1'b0;
      waiting_for_ack_next       = 1'b0;
      waiting_for_ack_clear_next = 1'b0;
      wait_count_next            = '0;
      accepted_valid_next        = 1'b0;
    end else if (held.target_valid) begin
      rsp_next.commanded_position = held.target_position;
      if (cfg.change_immediately) begin
        rsp_next.control_word[CHANGE_IMMEDIATE_BIT] = 1'b1;
      end

      priority if (waiting_for_ack_clear) begin
        if (ack) begin
          wait_count_next = count_inc;
        end
        if (!ack || expired) begin
          waiting_for_ack_clear_next = 1'b0;
        end
      end else if (waiting_for_ack) begin
        if (ack) begin
          setpoint_bit_high_next     = 1'b0;
          waiting_for_ack_next       = 1'b0;
          waiting_for_ack_clear_next = 1'b1;
          wait_count_next            = '0;
          accepted_valid_next        = 1'b1;
          accepted_target_next       = held.target_position;
        end else if (expired) begin
          setpoint_bit_high_next = 1'b0;
          waiting_for_ack_next   = 1'b0;
          wait_count_next        = '0;
        end else begin
          wait_count_next = count_inc;
        end
      end else if (!accepted_valid || accepted_target != held.target_position) begin
        setpoint_bit_high_next = 1'b1;
        waiting_for_ack_next   = 1'b1;
        wait_count_next        = '0;
      end else begin
        wait_count_next = wait_count;
      end

      if (setpoint_bit_high_next) begin
        rsp_next.control_word[NEW_SETPOINT_BIT] = 1'b1;
      end
    end
  end

  // Handshake state advances once per beat taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_bit_high     <= 1'b0;
      waiting_for_ack       <= 1'b0;
      waiting_for_ack_clear <= 1'b0;
      wait_count            <= '0;
      accepted_valid        <= 1'b0;
    end else if (take) begin
      setpoint_bit_high     <= setpoint_bit_high_next;
      waiting_for_ack       <= waiting_for_ack_next;
      waiting_for_ack_clear <= waiting_for_ack_clear_next;
      wait_count            <= wait_count_next;
      accepted_valid        <= accepted_valid_next;
    end
  end

  // The accepted target only matters while accepted_valid is set.
  always_ff @(posedge clk) begin
    if (take) begin
      accepted_target <= accepted_target_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

endmodule
